@@ src/xee_pkg.sv @@
`default_nettype none

package xee_pkg;

  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxChars = 7;
  localparam int unsigned LenW     = 3;

  localparam logic [CharW-1:0] ChAmp   = 7'h26;
  localparam logic [CharW-1:0] ChHash  = 7'h23;
  localparam logic [CharW-1:0] ChSemi  = 7'h3b;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChQuote = 7'h22;
  localparam logic [CharW-1:0] ChApos  = 7'h27;
  localparam logic [CharW-1:0] ChLt    = 7'h3c;
  localparam logic [CharW-1:0] ChGt    = 7'h3e;

  localparam logic [7:0] ByteEuro = 8'h80;
  localparam logic [7:0] ByteLow  = 8'h20;
  localparam logic [7:0] ByteHigh = 8'h7f;

  // One escaped sequence, first character in chars[0].
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [LenW-1:0]                len;
  } esc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } esc_qstat_t;

  function automatic logic [CharW-1:0] digit_char(logic [3:0] d);
    return ChZero + CharW'(d);
  endfunction

  function automatic esc_item_t classify(logic [7:0] b);
    esc_item_t   it;
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] prod;
    logic [3:0]  t;
    logic [3:0]  o;
    it   = '0;
    h    = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    r    = b - 8'(h) * 8'd100;
    // Tens digit by reciprocal multiply, exact for r below 100.
    prod = 16'(r) * 16'd205;
    t    = 4'(prod >> 11);
    o    = 4'(r - 8'(t) * 8'd10);
    priority if (b == {1'b0, ChQuote}) begin
      it.chars[0] = ChAmp; it.chars[1] = 7'h71; it.chars[2] = 7'h75;
      it.chars[3] = 7'h6f; it.chars[4] = 7'h74; it.chars[5] = ChSemi;
      it.len = 3'd6;
    end else if (b == {1'b0, ChApos}) begin
      it.chars[0] = ChAmp; it.chars[1] = 7'h61; it.chars[2] = 7'h70;
      it.chars[3] = 7'h6f; it.chars[4] = 7'h73; it.chars[5] = ChSemi;
      it.len = 3'd6;
    end else if (b == {1'b0, ChAmp}) begin
      it.chars[0] = ChAmp; it.chars[1] = 7'h61; it.chars[2] = 7'h6d;
      it.chars[3] = 7'h70; it.chars[4] = ChSemi;
      it.len = 3'd5;
    end else if (b == {1'b0, ChLt}) begin
      it.chars[0] = ChAmp; it.chars[1] = 7'h6c; it.chars[2] = 7'h74;
      it.chars[3] = ChSemi;
      it.len = 3'd4;
    end else if (b == {1'b0, ChGt}) begin
      it.chars[0] = ChAmp; it.chars[1] = 7'h67; it.chars[2] = 7'h74;
      it.chars[3] = ChSemi;
      it.len = 3'd4;
    end else if (b >= ByteLow && b <= ByteHigh) begin
      it.chars[0] = b[CharW-1:0];
      it.len = 3'd1;
    end else if (b == ByteEuro) begin
      it.chars[0] = ChAmp; it.chars[1] = ChHash; it.chars[2] = digit_char(4'd8);
      it.chars[3] = digit_char(4'd3); it.chars[4] = digit_char(4'd6);
      it.chars[5] = digit_char(4'd4); it.chars[6] = ChSemi;
      it.len = 3'd7;
    end else if (h != 2'd0) begin
      it.chars[0] = ChAmp; it.chars[1] = ChHash; it.chars[2] = digit_char(4'(h));
      it.chars[3] = digit_char(t); it.chars[4] = digit_char(o);
      it.chars[5] = ChSemi;
      it.len = 3'd6;
    end else if (t != 4'd0) begin
      it.chars[0] = ChAmp; it.chars[1] = ChHash; it.chars[2] = digit_char(t);
      it.chars[3] = digit_char(o); it.chars[4] = ChSemi;
      it.len = 3'd5;
    end else begin
      it.chars[0] = ChAmp; it.chars[1] = ChHash; it.chars[2] = digit_char(o);
      it.chars[3] = ChSemi;
      it.len = 3'd4;
    end
    return it;
  endfunction

endpackage

`default_nettype wire

@@ src/xml_entity_escaper.sv @@
// Escapes a byte stream into XML-safe ASCII text.
// The slave channel takes one raw byte per transfer on s_axis_tdata_i. The
// master channel gives one character per transfer; m_axis_tlast_o marks the
// final character produced for each input byte.
// Quote, apostrophe, ampersand, less-than and greater-than become their named
// entities, other bytes from 0x20 to 0x7f pass unchanged, 0x80 becomes the
// euro sign entity, and every other byte becomes a decimal character reference.
// A byte is classified on its way into a two-entry queue; the output sequencer
// reads the head entry and sends one character per cycle, while the receiver
// is ready, from a registered output stage. The first character of a byte
// passes through the queue entry and then the output register. A pass-through
// byte yields one character and an escaped byte 4 to 7 characters, while the
// queue keeps accepting bytes until both entries are full.
// When the receiver stalls, the output stage holds its character, then the
// queue fills and s_axis_tready_o drops.
// Reset empties the queue and the output stage; s_axis_tready_o is high
// as soon as reset is released.
`default_nettype none

module xml_entity_escaper (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [6:0] out_char, [7] zero
  output logic            m_axis_tlast_o
);

  xee_pkg::esc_qstat_t       q_stat;
  xee_pkg::esc_item_t        q_item;
  xee_pkg::esc_item_t        rd_item;
  logic                      q_push;
  logic                      q_pop;
  logic                      rd_valid;
  logic [xee_pkg::CharW-1:0] out_char;

  xee_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_byte_i  (s_axis_tdata_i),
    .s_ready_o (s_axis_tready_o),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_item_o  (q_item)
  );

  xee_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .item_i     (q_item),
    .pop_i      (q_pop),
    .rd_valid_o (rd_valid),
    .rd_item_o  (rd_item),
    .stat_o     (q_stat)
  );

  xee_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid),
    .rd_item_i  (rd_item),
    .pop_o      (q_pop),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_char_o   (out_char),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

  a_seq_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("Gap inside an escaped sequence.");

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("Queue reports full and empty at once.");

  a_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !q_stat.empty)
    else $error("Accepted byte did not reach the queue.");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> rd_valid)
    else $error("Queue popped while empty.");

endmodule

`default_nettype wire

@@ src/xee_front.sv @@
`default_nettype none

module xee_front (
  input  wire logic              s_valid_i,
  input  wire logic [7:0]        s_byte_i,
  output logic                   s_ready_o,
  input  wire xee_pkg::esc_qstat_t q_stat_i,
  output logic                   q_push_o,
  output xee_pkg::esc_item_t     q_item_o
);

  assign s_ready_o = !q_stat_i.full;
  assign q_push_o  = s_valid_i && !q_stat_i.full;
  assign q_item_o  = xee_pkg::classify(s_byte_i);

endmodule

`default_nettype wire

@@ src/xee_queue.sv @@
`default_nettype none

module xee_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire xee_pkg::esc_item_t item_i,
  input  wire logic               pop_i,
  output logic                    rd_valid_o,
  output xee_pkg::esc_item_t      rd_item_o,
  output xee_pkg::esc_qstat_t     stat_o
);

  xee_pkg::esc_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign rd_valid_o   = (count_q != 2'd0);
  assign rd_item_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

@@ src/xee_back.sv @@
`default_nettype none

module xee_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_valid_i,
  input  wire xee_pkg::esc_item_t rd_item_i,
  output logic                    pop_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [xee_pkg::CharW-1:0] m_char_o,
  output logic                    m_last_o
);

  logic [xee_pkg::LenW-1:0]  idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic [xee_pkg::CharW-1:0] char_q;
  logic                      last_q;
  logic                      load;
  logic                      is_last;

  always_comb begin
    load    = !valid_q || m_ready_i;
    is_last = (idx_q == rd_item_i.len - 3'd1);
    pop_o   = load && rd_valid_i && is_last;
    valid_d = load ? rd_valid_i : valid_q;
    idx_d   = idx_q;
    if (load && rd_valid_i) begin
      idx_d = is_last ? '0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && rd_valid_i) begin
      char_q <= rd_item_i.chars[idx_q];
      last_q <= is_last;
    end
  end

  assign m_valid_o = valid_q;
  assign m_char_o  = char_q;
  assign m_last_o  = last_q;

endmodule

`default_nettype wire

@@ verif/xml_entity_escaper_tb.sv @@
`timescale 1ns / 100ps

module xml_entity_escaper_tb;

  localparam logic [7:0] ByteQuote = 8'h22;
  localparam logic [7:0] ByteApos  = 8'h27;
  localparam logic [7:0] ByteAmp   = 8'h26;
  localparam logic [7:0] ByteLt    = 8'h3c;
  localparam logic [7:0] ByteGt    = 8'h3e;
  localparam logic [7:0] BytePound = 8'ha3;

  localparam int unsigned RandomBytes  = 450;
  localparam int unsigned HoldOffAfter = 200;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned TailCycles   = 10;

  typedef struct {
    logic [xee_pkg::CharW-1:0] ch;
    logic                      last;
  } esc_char_t;

  class escape_tracker;
    esc_char_t   expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function string escape_text(logic [7:0] b);
      string s;
      case (b)
        ByteQuote:         s = "&quot;";
        ByteApos:          s = "&apos;";
        ByteAmp:           s = "&amp;";
        ByteLt:            s = "&lt;";
        ByteGt:            s = "&gt;";
        BytePound:         s = "&#163;";
        xee_pkg::ByteEuro: s = "&#8364;";
        default: begin
          if (b >= xee_pkg::ByteLow && b <= xee_pkg::ByteHigh) begin
            s = $sformatf("%c", b);
          end else begin
            s = $sformatf("&#%0d;", b);
          end
        end
      endcase
      return s;
    endfunction

    function void note_byte(logic [7:0] b);
      string     s;
      byte       c;
      esc_char_t e;
      s = escape_text(b);
      for (int i = 0; i < s.len(); i++) begin
        c      = s[i];
        e.ch   = c[xee_pkg::CharW-1:0];
        e.last = (i == s.len() - 1);
        expected_chars.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_char(logic [7:0] data, logic last);
      esc_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", data, last));
      end else begin
        e = expected_chars.pop_front();
        if (data !== {1'b0, e.ch}) begin
          report($sformatf("char 0x%02h, expected 0x%02h", data, e.ch));
        end
        if (last !== e.last) begin
          report($sformatf("tlast %0b, expected %0b on char 0x%02h", last, e.last, e.ch));
        end
      end
    endtask
  endclass

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  escape_tracker esc_track = new();
  int unsigned   chars_seen = 0;
  int unsigned   idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  xml_entity_escaper uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials[9];
    int unsigned r;
    specials = '{ByteQuote, ByteApos, ByteAmp, ByteLt, ByteGt, xee_pkg::ByteEuro,
                 BytePound, 8'h00, xee_pkg::ByteHigh};
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(xee_pkg::ByteLow, xee_pkg::ByteHigh));
    if (r < 7) return specials[$urandom_range(0, 8)];
    return 8'($urandom_range(0, 255));
  endfunction

  task send_byte(input logic [7:0] b, input int unsigned gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        esc_track.note_byte(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        esc_track.check_char(m_tdata, m_tlast);
        chars_seen++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off that
  // lets the queue fill so that the input side stalls.
  initial begin
    int unsigned stall_left;
    int unsigned cycle_count;
    bit          recv_tight;
    bit          held_off;
    stall_left  = 0;
    cycle_count = 0;
    recv_tight  = 1'b0;
    held_off    = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (cycle_count % 256 == 0) recv_tight = ($urandom_range(0, 3) == 0);
      if (!held_off && chars_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
        cycle_count += HoldOffLen;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
        @(posedge clk_i);
        cycle_count++;
      end else begin
        m_tready <= 1'b1;
        if (!recv_tight) stall_left = pick_gap();
        @(posedge clk_i);
        cycle_count++;
      end
    end
  end

  initial begin
    logic [7:0] directed[$];
    bit         send_tight;
    directed = '{8'h00, 8'h01, 8'h09, 8'h0a, 8'h1f, xee_pkg::ByteLow, ByteQuote,
                 ByteApos, ByteAmp, ByteLt, ByteGt, 8'h41, 8'h7e, xee_pkg::ByteHigh,
                 xee_pkg::ByteEuro, 8'h81, 8'h99, BytePound, 8'hc7, 8'hc8, 8'hf0,
                 8'hff};
    send_tight = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i], pick_gap());

    for (int i = 0; i < RandomBytes; i++) begin
      if (i % 50 == 0) send_tight = ($urandom_range(0, 3) == 0);
      send_byte(pick_byte(), send_tight ? 0 : pick_gap());
    end
    s_tvalid <= 1'b0;
    @(posedge clk_i);

    while (esc_track.expected_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (esc_track.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
